>>> design/lcw_pkg.sv
// Shared types and constants for the line clipper.
// No dependencies; the interfaces and the top level import this package.
package lcw_pkg;

  localparam int CoordWidth  = 16;
  localparam int CodeWidth   = 4;
  localparam int CfgIdxWidth = 2;

  // Outcode bits
  localparam logic [CodeWidth-1:0] CODE_LEFT   = 4'b0001;
  localparam logic [CodeWidth-1:0] CODE_RIGHT  = 4'b0010;
  localparam logic [CodeWidth-1:0] CODE_BOTTOM = 4'b0100;
  localparam logic [CodeWidth-1:0] CODE_TOP    = 4'b1000;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_BOTTOM = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_RIGHT  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_TOP    = 2'd3;

  localparam logic signed [CoordWidth-1:0] COORD_ZERO = '0;
  localparam logic signed [CoordWidth-1:0] COORD_MAX  = {1'b0, {(CoordWidth-1){1'b1}}};

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    logic                 accepted;
    coord_t               clipped_start_x;
    coord_t               clipped_start_y;
    coord_t               clipped_end_x;
    coord_t               clipped_end_y;
    logic [CodeWidth-1:0] outcode_union;
  } res_t;

endpackage

>>> design/lcw_seg_if.sv
// Request channel carrying one line segment (two endpoints).
// Depends on lcw_pkg for the payload type.
interface lcw_seg_if;
  import lcw_pkg::*;

  logic valid;
  logic ready;
  seg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/lcw_res_if.sv
// Result channel carrying the clipped segment and the outcode union.
// Depends on lcw_pkg for the payload type.
interface lcw_res_if;
  import lcw_pkg::*;

  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/line_clip_to_window.sv
// A result is registered after k clip steps (0 to 4) following acceptance.
// Each clip step: operand selection, a multiply, the shared radix-4
// divider (two quotient bits a cycle) and a write-back.
// A new request is taken only after the last one's result is in
// the output register, even if that result has not yet been taken.
// Reset (rst_ni low, asynchronous): sequencer idle, no result pending, window 0..32767.
module line_clip_to_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcw_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [lcw_pkg::CoordWidth-1:0]  cfg_wdata_i,
  lcw_seg_if.sink                       seg_i,
  lcw_res_if.source                     res_o
);
  import lcw_pkg::*;

  localparam int DiffWidth = CoordWidth + 1;
  localparam int ProdWidth = 2 * CoordWidth;
  localparam int DivSteps  = ProdWidth / 2;
  localparam int CntWidth  = $clog2(DivSteps);
  localparam int ClipLimit = 4;
  localparam int IterWidth = $clog2(ClipLimit + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } win_t;

  function automatic logic [CodeWidth-1:0] region(input coord_t x, input coord_t y,
                                                  input win_t w);
    logic [CodeWidth-1:0] c;
    c = '0;
    if (x < w.left) begin
      c = c | CODE_LEFT;
    end else if (x > w.right) begin
      c = c | CODE_RIGHT;
    end
    if (y < w.bottom) begin
      c = c | CODE_BOTTOM;
    end else if (y > w.top) begin
      c = c | CODE_TOP;
    end
    return c;
  endfunction

  state_e                state_q, state_d;
  win_t                  win_q;
  coord_t                x1_q, y1_q, x2_q, y2_q;
  logic [CodeWidth-1:0]  c1_q, c2_q, uni_q;
  logic [IterWidth-1:0]  iter_q;
  logic                  acc_q;
  coord_t                edge_q;
  logic                  vert_q, side1_q, neg_q, zdiv_q;
  logic [CoordWidth-1:0] mag_a_q, mag_b_q, div_q, rem_q;
  logic [ProdWidth-1:0]  quo_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  out_valid_q;
  res_t                  out_q;

  // Operand selection for one clip step
  logic [CodeWidth-1:0]        co;
  logic                        co_vert;
  coord_t                      co_edge;
  logic signed [DiffWidth-1:0] op_a, op_b, op_c;
  logic [DiffWidth-1:0]        abs_a, abs_b, abs_c;

  always_comb begin
    co      = (c1_q != '0) ? c1_q : c2_q;
    co_vert = |(co & (CODE_TOP | CODE_BOTTOM));
    if (co_vert) begin
      co_edge = (|(co & CODE_TOP)) ? win_q.top : win_q.bottom;
      op_a    = {x2_q[CoordWidth-1], x2_q} - {x1_q[CoordWidth-1], x1_q};
      op_b    = {co_edge[CoordWidth-1], co_edge} - {y1_q[CoordWidth-1], y1_q};
      op_c    = {y2_q[CoordWidth-1], y2_q} - {y1_q[CoordWidth-1], y1_q};
    end else begin
      co_edge = (|(co & CODE_RIGHT)) ? win_q.right : win_q.left;
      op_a    = {y2_q[CoordWidth-1], y2_q} - {y1_q[CoordWidth-1], y1_q};
      op_b    = {co_edge[CoordWidth-1], co_edge} - {x1_q[CoordWidth-1], x1_q};
      op_c    = {x2_q[CoordWidth-1], x2_q} - {x1_q[CoordWidth-1], x1_q};
    end
    abs_a = op_a[DiffWidth-1] ? -op_a : op_a;
    abs_b = op_b[DiffWidth-1] ? -op_b : op_b;
    abs_c = op_c[DiffWidth-1] ? -op_c : op_c;
  end

  // Shared magnitude multiplier
  logic [ProdWidth-1:0] prod;
  assign prod = mag_a_q * mag_b_q;

  // Radix-4 restoring divider step: two dependent subtract-and-select stages
  logic [CoordWidth:0]   r0, r1;
  logic                  ge0, ge1;
  logic [CoordWidth-1:0] r0n, r1n;

  always_comb begin
    r0  = {rem_q, quo_q[ProdWidth-1]};
    ge0 = r0 >= {1'b0, div_q};
    r0n = ge0 ? CoordWidth'(r0 - {1'b0, div_q}) : r0[CoordWidth-1:0];
    r1  = {r0n, quo_q[ProdWidth-2]};
    ge1 = r1 >= {1'b0, div_q};
    r1n = ge1 ? CoordWidth'(r1 - {1'b0, div_q}) : r1[CoordWidth-1:0];
  end

  // Intersection write-back: only the low coordinate bits of the quotient survive the wrap
  logic [CoordWidth-1:0] q_lo, q_sgn;
  coord_t                base, isect, nx, ny;
  logic [CodeWidth-1:0]  new_code;

  always_comb begin
    q_lo     = zdiv_q ? '0 : quo_q[CoordWidth-1:0];
    q_sgn    = neg_q ? -q_lo : q_lo;
    base     = vert_q ? x1_q : y1_q;
    isect    = base + q_sgn;
    nx       = vert_q ? isect : edge_q;
    ny       = vert_q ? edge_q : isect;
    new_code = region(nx, ny, win_q);
  end

  logic seg_acc, res_acc;
  assign seg_acc = seg_i.valid & seg_i.ready;
  assign res_acc = res_o.valid & res_o.ready;

  assign seg_i.ready   = (state_q == ST_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (seg_acc) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if ((c1_q == '0 && c2_q == '0) || (c1_q & c2_q) != '0 ||
            iter_q == IterWidth'(ClipLimit)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntWidth'(DivSteps - 1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_CHECK;
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= '{left: COORD_ZERO, bottom: COORD_ZERO, right: COORD_MAX, top: COORD_MAX};
      iter_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEFT:   win_q.left   <= cfg_wdata_i;
          CFG_BOTTOM: win_q.bottom <= cfg_wdata_i;
          CFG_RIGHT:  win_q.right  <= cfg_wdata_i;
          CFG_TOP:    win_q.top    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (seg_acc) iter_q <= '0;
      else if (state_q == ST_UPDATE) iter_q <= iter_q + 1'b1;
      if (state_q == ST_DIV) begin
        cnt_q <= (cnt_q == CntWidth'(DivSteps - 1)) ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ST_DONE && (!out_valid_q || res_o.ready)) out_valid_q <= 1'b1;
      else if (res_acc) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (seg_acc) begin
          x1_q  <= seg_i.payload.start_x;
          y1_q  <= seg_i.payload.start_y;
          x2_q  <= seg_i.payload.end_x;
          y2_q  <= seg_i.payload.end_y;
          c1_q  <= region(seg_i.payload.start_x, seg_i.payload.start_y, win_q);
          c2_q  <= region(seg_i.payload.end_x, seg_i.payload.end_y, win_q);
          uni_q <= region(seg_i.payload.start_x, seg_i.payload.start_y, win_q) |
                   region(seg_i.payload.end_x, seg_i.payload.end_y, win_q);
        end
      end
      ST_CHECK: begin
        acc_q   <= (c1_q == '0 && c2_q == '0);
        edge_q  <= co_edge;
        vert_q  <= co_vert;
        side1_q <= (c1_q != '0);
        neg_q   <= op_a[DiffWidth-1] ^ op_b[DiffWidth-1] ^ op_c[DiffWidth-1];
        mag_a_q <= abs_a[CoordWidth-1:0];
        mag_b_q <= abs_b[CoordWidth-1:0];
        div_q   <= abs_c[CoordWidth-1:0];
      end
      ST_MUL: begin
        quo_q  <= prod;
        rem_q  <= '0;
        zdiv_q <= (div_q == '0);
      end
      ST_DIV: begin
        rem_q <= r1n;
        quo_q <= {quo_q[ProdWidth-3:0], ge0, ge1};
      end
      ST_UPDATE: begin
        if (side1_q) begin
          x1_q <= nx;
          y1_q <= ny;
          c1_q <= new_code;
        end else begin
          x2_q <= nx;
          y2_q <= ny;
          c2_q <= new_code;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_q.accepted        <= acc_q;
          out_q.clipped_start_x <= acc_q ? x1_q : COORD_ZERO;
          out_q.clipped_start_y <= acc_q ? y1_q : COORD_ZERO;
          out_q.clipped_end_x   <= acc_q ? x2_q : COORD_ZERO;
          out_q.clipped_end_y   <= acc_q ? y2_q : COORD_ZERO;
          out_q.outcode_union   <= uni_q;
        end
      end
      default: ;
    endcase
  end

  // Divider count only runs inside the divide phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (cnt_q == '0))
    else $error("divider count left non-zero outside divide phase");

  // Never more clip steps than the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= IterWidth'(ClipLimit))
    else $error("clip step count beyond limit");

  // A write-back always returns to the outcode test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_CHECK))
    else $error("sequencer skipped outcode test after write-back");

  // An accepted segment only leaves with both endpoints inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && acc_q) |-> (c1_q == '0 && c2_q == '0))
    else $error("accept flagged with an endpoint outside the window");

  // A rejected result carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.accepted) |->
      (out_q.clipped_start_x == COORD_ZERO && out_q.clipped_start_y == COORD_ZERO &&
       out_q.clipped_end_x == COORD_ZERO && out_q.clipped_end_y == COORD_ZERO))
    else $error("rejected result with non-zero coordinates");

endmodule
